@@ hdl/qrm_pkg.sv @@
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared types and constants for the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int Q_W       = 16;                 // quaternion / matrix field width
    localparam int PROD_W    = 2 * Q_W;            // one signed product
    localparam int NORM_W    = PROD_W + 1;         // sum of four squares, unsigned
    localparam int NUM_W     = PROD_W + 3;         // signed numerator
    localparam int MAG_W     = NORM_W;             // |numerator| <= norm
    localparam int QUO_W     = FRAC_BITS + 1;      // quotient 0..16384
    localparam int DIV_W     = NORM_W + 1;         // divisor 2*norm
    localparam int REM_W     = DIV_W + QUO_W - 1;  // dividend width
    localparam int N_ENT     = 9;
    localparam int PRE_STG   = 4;                  // input, product, sum, setup
    localparam int N_STG     = PRE_STG + QUO_W + 1;

    localparam logic [QUO_W-1:0] ONE_Q = QUO_W'(1) << FRAC_BITS;

    typedef logic signed [Q_W-1:0]    t_q;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic        [NORM_W-1:0] t_norm;
    typedef logic signed [NUM_W-1:0]  t_num;
    typedef logic        [REM_W-1:0]  t_rem;
    typedef logic        [DIV_W-1:0]  t_dvs;
    typedef logic        [QUO_W-1:0]  t_quo;

endpackage

@@ hdl/qrm_if.sv @@
// ----------------------------------------------------------------------------
// qrm_if
// Ready/valid channels for quaternion beats and matrix beats.
// ----------------------------------------------------------------------------
interface qrm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;

    modport source (output valid, qw, qx, qy, qz, input ready);
    modport sink   (input valid, qw, qx, qy, qz, output ready);
endinterface

interface qrm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               zero_norm;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    zero_norm, input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    zero_norm, output ready);
endinterface

@@ hdl/qrm_div.sv @@
// ----------------------------------------------------------------------------
// qrm_div
// Pipelined restoring divider lane, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrm_div
    import qrm_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_rem i_dividend,
    input  t_dvs i_divisor,
    input  logic i_neg,
    output t_quo o_quo,
    output logic o_neg
);

    t_rem r_rem [QUO_W];
    t_dvs r_dvs [QUO_W];
    t_quo r_quo [QUO_W];
    logic r_neg [QUO_W];

    genvar s;
    generate
        for (s = 0; s < QUO_W; s++) begin : g_stg
            t_rem p_rem;
            t_dvs p_dvs;
            t_quo p_quo;
            logic p_neg;
            t_rem w_sub;
            logic w_ge;

            if (s == 0) begin : g_first
                assign p_rem = i_dividend;
                assign p_dvs = i_divisor;
                assign p_quo = '0;
                assign p_neg = i_neg;
            end else begin : g_rest
                assign p_rem = r_rem[s-1];
                assign p_dvs = r_dvs[s-1];
                assign p_quo = r_quo[s-1];
                assign p_neg = r_neg[s-1];
            end

            assign w_sub = REM_W'(p_dvs) << (QUO_W - 1 - s);
            assign w_ge  = (p_rem >= w_sub);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_ge ? (p_rem - w_sub) : p_rem;
                    r_dvs[s] <= p_dvs;
                    r_quo[s] <= p_quo | (QUO_W'(w_ge) << (QUO_W - 1 - s));
                    r_neg[s] <= p_neg;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[QUO_W-1];
    assign o_neg = r_neg[QUO_W-1];

endmodule

@@ hdl/quaternion_to_rotation_matrix_top.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_top
// Q2.14 quaternion to normalized 3x3 rotation matrix, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          beat
//  i_in     in   qw qx qy qz (s16 Q2.14)          valid & ready
//  o_out    out  m00..m22 (s16 Q2.14), zero_norm  valid & ready
//
//  One beat per cycle unless stalled; stages: input, products, sums,
//  divide setup, 15 restoring-divide stages (one quotient bit each), output
//  register. Reset (synchronous, active low) clears only the valid bits.
//  The whole pipeline holds while the output beat waits; i_in.ready is low
//  only then.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_top
    import qrm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    qrm_in_if.sink      i_in,
    qrm_out_if.source   o_out
);

    logic w_en;
    logic r_vld  [N_STG];
    logic r_zero [N_STG];

    t_q    r_w, r_x, r_y, r_z;
    t_prod r_ww, r_xx, r_yy, r_zz, r_xy, r_zw, r_xz, r_yw, r_yz, r_xw;
    t_norm r_n;
    t_num  r_num [N_ENT];
    t_rem  r_dvd [N_ENT];
    t_dvs  r_dvs;
    logic  r_neg [N_ENT];
    t_q    r_m   [N_ENT];

    t_num  w_num [N_ENT];
    t_quo  w_quo [N_ENT];
    logic  w_qneg[N_ENT];

    assign w_en       = !r_vld[N_STG-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_STG; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k < N_STG; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero[0] <= (i_in.qw == '0) && (i_in.qx == '0) &&
                         (i_in.qy == '0) && (i_in.qz == '0);
            for (int k = 1; k < N_STG; k++) r_zero[k] <= r_zero[k-1];
            r_w <= i_in.qw;
            r_x <= i_in.qx;
            r_y <= i_in.qy;
            r_z <= i_in.qz;
        end
    end

    // products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ww <= r_w * r_w;
            r_xx <= r_x * r_x;
            r_yy <= r_y * r_y;
            r_zz <= r_z * r_z;
            r_xy <= r_x * r_y;
            r_zw <= r_z * r_w;
            r_xz <= r_x * r_z;
            r_yw <= r_y * r_w;
            r_yz <= r_y * r_z;
            r_xw <= r_x * r_w;
        end
    end

    // numerators in row-major order
    always_comb begin
        w_num[0] = NUM_W'(r_ww) + NUM_W'(r_xx) - NUM_W'(r_yy) - NUM_W'(r_zz);
        w_num[1] = (NUM_W'(r_xy) - NUM_W'(r_zw)) <<< 1;
        w_num[2] = (NUM_W'(r_xz) + NUM_W'(r_yw)) <<< 1;
        w_num[3] = (NUM_W'(r_xy) + NUM_W'(r_zw)) <<< 1;
        w_num[4] = NUM_W'(r_ww) - NUM_W'(r_xx) + NUM_W'(r_yy) - NUM_W'(r_zz);
        w_num[5] = (NUM_W'(r_yz) - NUM_W'(r_xw)) <<< 1;
        w_num[6] = (NUM_W'(r_xz) - NUM_W'(r_yw)) <<< 1;
        w_num[7] = (NUM_W'(r_yz) + NUM_W'(r_xw)) <<< 1;
        w_num[8] = NUM_W'(r_ww) - NUM_W'(r_xx) - NUM_W'(r_yy) + NUM_W'(r_zz);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n <= NORM_W'($unsigned(r_ww)) + NORM_W'($unsigned(r_xx)) +
                   NORM_W'($unsigned(r_yy)) + NORM_W'($unsigned(r_zz));
            for (int k = 0; k < N_ENT; k++) r_num[k] <= w_num[k];
        end
    end

    // divide setup: dividend |num|*2^15 + n, divisor 2n (round half away)
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dvs <= {r_n, 1'b0};
            for (int k = 0; k < N_ENT; k++) begin
                r_neg[k] <= r_num[k][NUM_W-1];
                r_dvd[k] <= (REM_W'(MAG_W'(r_num[k][NUM_W-1] ? -r_num[k] : r_num[k]))
                             << (FRAC_BITS + 1)) + REM_W'(r_n);
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < N_ENT; g++) begin : g_lane
            qrm_div u_div (
                .i_clk      (i_clk),
                .i_en       (w_en),
                .i_dividend (r_dvd[g]),
                .i_divisor  (r_dvs),
                .i_neg      (r_neg[g]),
                .o_quo      (w_quo[g]),
                .o_neg      (w_qneg[g])
            );
        end
    endgenerate

    // saturate, restore sign, substitute identity for a zero quaternion
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < N_ENT; k++) begin
                if (r_zero[N_STG-2]) begin
                    r_m[k] <= (k % 4 == 0) ? t_q'(ONE_Q) : '0;
                end else if (w_quo[k] > ONE_Q) begin
                    r_m[k] <= w_qneg[k] ? -t_q'(ONE_Q) : t_q'(ONE_Q);
                end else begin
                    r_m[k] <= w_qneg[k] ? -t_q'(w_quo[k]) : t_q'(w_quo[k]);
                end
            end
        end
    end

    assign o_out.valid     = r_vld[N_STG-1];
    assign o_out.zero_norm = r_zero[N_STG-1];
    assign o_out.m00       = r_m[0];
    assign o_out.m01       = r_m[1];
    assign o_out.m02       = r_m[2];
    assign o_out.m10       = r_m[3];
    assign o_out.m11       = r_m[4];
    assign o_out.m12       = r_m[5];
    assign o_out.m20       = r_m[6];
    assign o_out.m21       = r_m[7];
    assign o_out.m22       = r_m[8];

endmodule
